### design/shp3_pkg.sv
// ----------------------------------------------------------------------------
// shp3_pkg: types and constants of the 3x3 RGB sharpening filter
// Word formats, register indexes and the fixed arithmetic constants.
// ----------------------------------------------------------------------------
`default_nettype none

package shp3_pkg;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 12;
  localparam int DIM_W      = 12;
  localparam int ROW_W      = DIM_W + 1;
  localparam int WEIGHT_W   = 8;
  localparam int CHAN_W     = 8;
  localparam int PIX_W      = 3 * CHAN_W;
  localparam int NSUM_W     = CHAN_W + 3;
  localparam int CPROD_W    = WEIGHT_W + CHAN_W;
  localparam int NPROD_W    = WEIGHT_W + NSUM_W;
  localparam int DIFF_W     = NPROD_W + 1;
  localparam int QIN_W      = 12;
  localparam int RECIP_W    = 12;
  localparam int DIV_SHIFT  = 15;

  localparam logic [RECIP_W-1:0] DIV_RECIP = 12'd3277;
  localparam logic [DIFF_W-1:0]  SAT_LIMIT = DIFF_W'(2560);
  localparam logic [CHAN_W-1:0]  CHAN_MAX  = 8'd255;

  localparam int MIN_DIM          = 3;
  localparam int FRAME_WIDTH_RST  = 640;
  localparam int FRAME_HEIGHT_RST = 480;
  localparam int CENTER_W_RST     = 20;
  localparam int NEIGHBOR_W_RST   = 1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FRAME_WIDTH,
    CFG_FRAME_HEIGHT,
    CFG_CENTER_WEIGHT,
    CFG_NEIGHBOR_WEIGHT
  } cfg_idx_e;

  typedef struct packed {
    logic [CHAN_W-1:0] blue_in;
    logic [CHAN_W-1:0] green_in;
    logic [CHAN_W-1:0] red_in;
  } in_word_t;

  typedef struct packed {
    logic [CHAN_W-1:0] blue_out;
    logic [CHAN_W-1:0] green_out;
    logic [CHAN_W-1:0] red_out;
    logic              out_valid;
    logic              frame_last;
  } out_word_t;

  typedef struct packed {
    logic pxv;
    logic border;
    logic last;
  } ctl_t;

  typedef logic [8:0][CHAN_W-1:0] chan_win_t;

endpackage

`default_nettype wire

### design/shp3_chan.sv
// ----------------------------------------------------------------------------
// shp3_chan: sharpening arithmetic for one color channel
// Neighbor sum, weight products, difference and saturating divide by ten.
// ----------------------------------------------------------------------------
`default_nettype none

module shp3_chan (
  input  wire logic                          clk_i,
  input  wire logic                          en_i,
  input  wire logic [shp3_pkg::WEIGHT_W-1:0] cw_i,
  input  wire logic [shp3_pkg::WEIGHT_W-1:0] nw_i,
  input  wire shp3_pkg::chan_win_t           win_i,
  output logic      [shp3_pkg::CHAN_W-1:0]   res_o
);
  import shp3_pkg::*;

  logic [CHAN_W-1:0]           ctr_q;
  logic [NSUM_W-1:0]           nsum_d, nsum_q;
  logic [CPROD_W-1:0]          cprod_q;
  logic [NPROD_W-1:0]          nprod_q;
  logic [DIFF_W-1:0]           diff;
  logic                        neg_q, big_q;
  logic [QIN_W-1:0]            x_q;
  logic [QIN_W+RECIP_W-1:0]    recip_prod;

  always_comb begin
    nsum_d = '0;
    for (int k = 0; k < 9; k++) begin
      if (k != 4) begin
        nsum_d = nsum_d + NSUM_W'(win_i[k]);
      end
    end
  end

  assign diff = DIFF_W'(cprod_q) - DIFF_W'(nprod_q);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ctr_q   <= win_i[4];
      nsum_q  <= nsum_d;
      cprod_q <= cw_i * ctr_q;
      nprod_q <= NPROD_W'(nw_i) * NPROD_W'(nsum_q);
      neg_q   <= diff[DIFF_W-1];
      big_q   <= !diff[DIFF_W-1] && (diff >= SAT_LIMIT);
      x_q     <= diff[QIN_W-1:0];
    end
  end

  // x < 2560 here, so the reciprocal product gives floor(x/10) exactly
  assign recip_prod = x_q * DIV_RECIP;

  always_comb begin
    if (neg_q) begin
      res_o = '0;
    end else if (big_q) begin
      res_o = CHAN_MAX;
    end else begin
      res_o = recip_prod[DIV_SHIFT +: CHAN_W];
    end
  end

endmodule

`default_nettype wire

### design/sharpen_3x3_rgb_filter.sv
// ----------------------------------------------------------------------------
// sharpen_3x3_rgb_filter: streaming 3x3 sharpening filter for RGB pixels
//
// Pixels enter in raster order on in_word_i (in_valid_i / in_stall_o) and
// one word leaves on out_word_o (out_valid_o / out_stall_i) for every word
// taken. The result runs one row and one column behind the input; the host
// appends frame_width+1 padding words per frame to drain it. out_valid in
// the word marks real frame pixels, frame_last the final one of a frame.
// Border pixels pass through; interior pixels get the weighted kernel.
// Throughput is one word per cycle; a word passes through the pipeline
// stages and the output register. Both line buffers share one MAX_WIDTH x
// 48 bit memory, read as a word is taken and written back by the following
// stage, with forwarding when two consecutive words hit the same column.
// A stall on the output holds the whole pipeline and raises in_stall_o
// while a word waits in the output register. Reset empties the pipeline,
// zeroes the position counters and loads the default geometry and weights;
// the line buffer memory needs no clearing. The configuration port is
// always ready; a geometry write restarts the frame position.
// ----------------------------------------------------------------------------
`default_nettype none

module sharpen_3x3_rgb_filter #(
  parameter int MAX_WIDTH = 2048
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            in_valid_i,
  output logic                                 in_stall_o,
  input  wire shp3_pkg::in_word_t              in_word_i,
  output logic                                 out_valid_o,
  input  wire logic                            out_stall_i,
  output shp3_pkg::out_word_t                  out_word_o,
  input  wire logic                            cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  wire logic [shp3_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [shp3_pkg::CFG_DATA_W-1:0] cfg_data_i
);
  import shp3_pkg::*;

  localparam int COL_W     = $clog2(MAX_WIDTH);
  localparam int WW        = $clog2(MAX_WIDTH + 1);
  localparam int CMP_W     = (WW > CFG_DATA_W) ? WW : CFG_DATA_W;
  localparam int WIDTH_RST = (FRAME_WIDTH_RST > MAX_WIDTH) ? MAX_WIDTH : FRAME_WIDTH_RST;
  localparam int LB_W      = 2 * PIX_W;

  // configuration
  logic [WW-1:0]       eff_w_q;
  logic [DIM_W-1:0]    eff_h_q;
  logic [WEIGHT_W-1:0] cw_q, nw_q;
  logic [CMP_W-1:0]    wdata_ext;
  logic [WW-1:0]       w_clamped;
  logic [DIM_W-1:0]    h_clamped;
  logic                cfg_wr, geom_wr;

  // position and issue
  logic [COL_W-1:0] col_q, col_d, col_cur;
  logic [ROW_W-1:0] row_q, row_d;
  logic             en, in_acc, wrap;
  ctl_t             ctl0;
  logic [PIX_W-1:0] pix0;

  // line buffer memory
  logic [LB_W-1:0]  lbuf_mem [MAX_WIDTH];
  logic [LB_W-1:0]  rd_q, fwd_data_q, lb_rd, wr_data;
  logic             fwd_q;

  // pipeline
  logic             s1_v_q, s2_v_q, s3_v_q, s4_v_q, s5_v_q, out_v_q;
  ctl_t             s1_ctl_q, s2_ctl_q, s3_ctl_q, s4_ctl_q, s5_ctl_q;
  logic [PIX_W-1:0] s1_pix_q, s3_ctr_q, s4_ctr_q, s5_ctr_q;
  logic [COL_W-1:0] s1_ic_q;
  logic [8:0][PIX_W-1:0] window_q;
  chan_win_t        win_ch [3];
  logic [CHAN_W-1:0] res_ch [3];
  out_word_t        out_word_q;

  assign cfg_ready_o = 1'b1;
  assign cfg_wr      = cfg_valid_i && cfg_ready_o;
  assign geom_wr     = cfg_wr && ((cfg_index_i == CFG_FRAME_WIDTH) ||
                                  (cfg_index_i == CFG_FRAME_HEIGHT));

  always_comb begin
    wdata_ext = CMP_W'(cfg_data_i);
    if (wdata_ext < CMP_W'(MIN_DIM)) begin
      w_clamped = WW'(MIN_DIM);
    end else if (wdata_ext > CMP_W'(MAX_WIDTH)) begin
      w_clamped = WW'(MAX_WIDTH);
    end else begin
      w_clamped = WW'(wdata_ext);
    end
    h_clamped = (cfg_data_i < CFG_DATA_W'(MIN_DIM)) ? DIM_W'(MIN_DIM) : DIM_W'(cfg_data_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      eff_w_q <= WW'(WIDTH_RST);
      eff_h_q <= DIM_W'(FRAME_HEIGHT_RST);
      cw_q    <= WEIGHT_W'(CENTER_W_RST);
      nw_q    <= WEIGHT_W'(NEIGHBOR_W_RST);
    end else if (cfg_wr) begin
      case (cfg_index_i)
        CFG_FRAME_WIDTH:     eff_w_q <= w_clamped;
        CFG_FRAME_HEIGHT:    eff_h_q <= h_clamped;
        CFG_CENTER_WEIGHT:   cw_q    <= cfg_data_i[WEIGHT_W-1:0];
        CFG_NEIGHBOR_WEIGHT: nw_q    <= cfg_data_i[WEIGHT_W-1:0];
        default: ;
      endcase
    end
  end

  // global advance: everything moves unless a word waits on a stalled output
  assign en         = !(out_v_q && out_stall_i);
  assign in_stall_o = !en;
  assign in_acc     = in_valid_i && en;

  assign pix0 = {in_word_i.red_in, in_word_i.green_in, in_word_i.blue_in};

  always_comb begin
    col_cur     = (WW'(col_q) >= eff_w_q) ? '0 : col_q;
    ctl0.pxv    = (row_q >= ROW_W'(2)) || ((row_q == ROW_W'(1)) && (col_cur != '0));
    ctl0.border = (col_cur < COL_W'(2)) || (row_q == ROW_W'(1)) ||
                  (row_q >= ROW_W'(eff_h_q));
    ctl0.last   = row_q > ROW_W'(eff_h_q);
    wrap        = ((WW+1)'(col_cur) + (WW+1)'(1)) >= (WW+1)'(eff_w_q);
    if (ctl0.last) begin
      col_d = '0;
      row_d = '0;
    end else if (wrap) begin
      col_d = '0;
      row_d = row_q + ROW_W'(1);
    end else begin
      col_d = col_cur + COL_W'(1);
      row_d = row_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else if (geom_wr) begin
      col_q <= '0;
      row_q <= '0;
    end else if (in_acc) begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

  // stage 1: buffer data back from memory, new column written back
  assign lb_rd   = fwd_q ? fwd_data_q : rd_q;
  assign wr_data = {lb_rd[PIX_W-1:0], s1_pix_q};

  always_ff @(posedge clk_i) begin
    if (en && s1_v_q) begin
      lbuf_mem[s1_ic_q] <= wr_data;
    end
    if (in_acc) begin
      rd_q <= lbuf_mem[col_cur];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_q <= 1'b0;
    end else if (en) begin
      fwd_q <= s1_v_q && in_acc && (col_cur == s1_ic_q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      fwd_data_q <= wr_data;
      s1_pix_q   <= pix0;
      s1_ic_q    <= col_cur;
      s1_ctl_q   <= ctl0;
      s2_ctl_q   <= s1_ctl_q;
      s3_ctl_q   <= s2_ctl_q;
      s4_ctl_q   <= s3_ctl_q;
      s5_ctl_q   <= s4_ctl_q;
      s3_ctr_q   <= window_q[4];
      s4_ctr_q   <= s3_ctr_q;
      s5_ctr_q   <= s4_ctr_q;
    end
    if (en && s1_v_q) begin
      for (int r = 0; r < 3; r++) begin
        window_q[r*3+0] <= window_q[r*3+1];
        window_q[r*3+1] <= window_q[r*3+2];
      end
      window_q[2] <= lb_rd[LB_W-1:PIX_W];
      window_q[5] <= lb_rd[PIX_W-1:0];
      window_q[8] <= s1_pix_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q  <= 1'b0;
      s2_v_q  <= 1'b0;
      s3_v_q  <= 1'b0;
      s4_v_q  <= 1'b0;
      s5_v_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else if (en) begin
      s1_v_q  <= in_acc;
      s2_v_q  <= s1_v_q;
      s3_v_q  <= s2_v_q;
      s4_v_q  <= s3_v_q;
      s5_v_q  <= s4_v_q;
      out_v_q <= s5_v_q;
    end
  end

  // stages 2..5: per-channel arithmetic
  for (genvar ch = 0; ch < 3; ch++) begin : g_chan
    always_comb begin
      for (int k = 0; k < 9; k++) begin
        win_ch[ch][k] = window_q[k][ch*CHAN_W +: CHAN_W];
      end
    end

    shp3_chan u_chan (
      .clk_i (clk_i),
      .en_i  (en),
      .cw_i  (cw_q),
      .nw_i  (nw_q),
      .win_i (win_ch[ch]),
      .res_o (res_ch[ch])
    );
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      if (!s5_ctl_q.pxv) begin
        out_word_q <= '0;
      end else begin
        if (s5_ctl_q.border) begin
          out_word_q.blue_out  <= s5_ctr_q[0 +: CHAN_W];
          out_word_q.green_out <= s5_ctr_q[CHAN_W +: CHAN_W];
          out_word_q.red_out   <= s5_ctr_q[2*CHAN_W +: CHAN_W];
        end else begin
          out_word_q.blue_out  <= res_ch[0];
          out_word_q.green_out <= res_ch[1];
          out_word_q.red_out   <= res_ch[2];
        end
        out_word_q.out_valid  <= 1'b1;
        out_word_q.frame_last <= s5_ctl_q.last;
      end
    end
  end

  assign out_valid_o = out_v_q;
  assign out_word_o  = out_word_q;

  a_last_is_pixel: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_word_o.frame_last |-> out_word_o.out_valid)
    else $error("frame_last on a warm-up word");

  a_warmup_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_word_o.out_valid |->
      (out_word_o.blue_out == '0) && (out_word_o.green_out == '0) &&
      (out_word_o.red_out == '0))
    else $error("warm-up word carries pixel data");

  a_col_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    WW'(col_q) < eff_w_q)
    else $error("column counter beyond frame width");

  a_row_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    row_q <= (ROW_W'(eff_h_q) + ROW_W'(1)))
    else $error("row counter beyond drain row");

  a_fwd_owner: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fwd_q |-> s1_v_q)
    else $error("forwarded buffer data without a word in stage 1");

endmodule

`default_nettype wire
